/* design/rbdt_pkg.sv */
// Package: shared types and constants for the rigid body derived transform.
package rbdt_pkg;
  localparam int NUM_REGS = 6;
  localparam int ROWS = 6;

  localparam logic [2:0] REG_XX = 3'd0;
  localparam logic [2:0] REG_YY = 3'd1;
  localparam logic [2:0] REG_ZZ = 3'd2;
  localparam logic [2:0] REG_XY = 3'd3;
  localparam logic [2:0] REG_XZ = 3'd4;
  localparam logic [2:0] REG_YZ = 3'd5;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         row_index;
    logic signed [31:0] col_a;
    logic signed [31:0] col_b;
    logic signed [31:0] col_c;
    logic signed [31:0] col_d;
    logic               last;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_word_t;

  // rotation matrix plus translation, as queued between front and back
  typedef struct packed {
    logic signed [8:0][31:0] r;
    logic signed [2:0][31:0] pos;
  } xform_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    if (v > 48'sd2147483647) return 32'h7fffffff;
    if (v < -48'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction
endpackage

/* design/rbdt_if.sv */
// Interfaces: valid/ready channels for input, result and configuration words.
interface rbdt_in_if;
  import rbdt_pkg::*;
  logic valid;
  logic ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbdt_out_if;
  import rbdt_pkg::*;
  logic valid;
  logic ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rbdt_cfg_if;
  import rbdt_pkg::*;
  logic valid;
  logic ready;
  cfg_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/rbdt_front.sv */
// Front: quaternion to rotation matrix, two registered stages.
module rbdt_front
  import rbdt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_word_t in_data,
  output logic     f_valid,
  input  logic     f_ready,
  output xform_t   f_data
);
  // stage 1: products
  logic signed [31:0] p_r [10];
  logic signed [31:0] pos_r [3];
  logic s1_valid_r;
  logic s2_valid_r;
  xform_t s2_r;
  logic adv2;
  logic adv1;

  assign adv2 = !s2_valid_r || f_ready;
  assign adv1 = !s1_valid_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (adv1) s1_valid_r <= in_valid;
      if (adv2) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      p_r[0] <= in_data.quat_x * in_data.quat_x;
      p_r[1] <= in_data.quat_y * in_data.quat_y;
      p_r[2] <= in_data.quat_z * in_data.quat_z;
      p_r[3] <= in_data.quat_x * in_data.quat_y;
      p_r[4] <= in_data.quat_x * in_data.quat_z;
      p_r[5] <= in_data.quat_y * in_data.quat_z;
      p_r[6] <= in_data.quat_w * in_data.quat_x;
      p_r[7] <= in_data.quat_w * in_data.quat_y;
      p_r[8] <= in_data.quat_w * in_data.quat_z;
      p_r[9] <= 32'sd0;
      pos_r[0] <= in_data.pos_x;
      pos_r[1] <= in_data.pos_y;
      pos_r[2] <= in_data.pos_z;
    end
  end

  function automatic logic signed [31:0] rnd(input logic signed [35:0] raw);
    logic signed [35:0] t;
    t = raw + 36'sd2048;
    return sat32(48'(t >>> 12));
  endfunction

  logic signed [35:0] ONE;
  logic signed [35:0] e [9];
  assign ONE = 36'sd268435456;
  always_comb begin
    e[0] = ONE - 36'(p_r[1]) * 2 - 36'(p_r[2]) * 2;
    e[1] = 36'(p_r[3]) * 2 - 36'(p_r[8]) * 2;
    e[2] = 36'(p_r[4]) * 2 + 36'(p_r[7]) * 2;
    e[3] = 36'(p_r[3]) * 2 + 36'(p_r[8]) * 2;
    e[4] = ONE - 36'(p_r[0]) * 2 - 36'(p_r[2]) * 2;
    e[5] = 36'(p_r[5]) * 2 - 36'(p_r[6]) * 2 + 36'(p_r[9]);
    e[6] = 36'(p_r[4]) * 2 - 36'(p_r[7]) * 2;
    e[7] = 36'(p_r[5]) * 2 + 36'(p_r[6]) * 2;
    e[8] = ONE - 36'(p_r[0]) * 2 - 36'(p_r[1]) * 2;
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid_r) begin
      for (int i = 0; i < 9; i++) s2_r.r[i] <= rnd(e[i]);
      for (int i = 0; i < 3; i++) s2_r.pos[i] <= pos_r[i];
    end
  end

  assign f_valid = s2_valid_r;
  assign f_data = s2_r;
endmodule

/* design/rbdt_queue.sv */
// Queue: short FIFO of transforms between front and back.
module rbdt_queue
  import rbdt_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  xform_t wr_data,
  output logic   rd_valid,
  input  logic   rd_ready,
  output xform_t rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  xform_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != (AW+1)'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= inc(wp_r);
      if (rd) rp_r <= inc(rp_r);
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

/* design/rbdt_back.sv */
// Back: one row per cycle unless stalled; separate three-lane MACs for T and W.
module rbdt_back
  import rbdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_ready,
  input  xform_t             q_data,
  input  logic signed [31:0] inertia [NUM_REGS],
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data
);
  // Schedule per item, steps 0..5, each held while the output is stalled:
  // steps 0-2 emit transform rows and compute T rows 0-2 (stage A).
  // W[i][j] = sum_k T[i][k] R[j][k] needs only row i of T,
  // so row i of W is computed from T row i at step i+3.
  xform_t cur_r;
  logic busy_r;
  logic [2:0] step_r;
  logic signed [39:0] t_r [3];
  logic signed [31:0] wrow [3];
  out_word_t o_r;
  logic o_valid_r;
  logic adv;
  logic signed [31:0] ib [3][3];
  logic [1:0] ti;

  assign adv = !o_valid_r || out_ready;
  assign q_ready = adv && (!busy_r || step_r == 3'd5);

  always_comb begin
    ib[0][0] = inertia[REG_XX]; ib[1][1] = inertia[REG_YY]; ib[2][2] = inertia[REG_ZZ];
    ib[0][1] = inertia[REG_XY]; ib[1][0] = inertia[REG_XY];
    ib[0][2] = inertia[REG_XZ]; ib[2][0] = inertia[REG_XZ];
    ib[1][2] = inertia[REG_YZ]; ib[2][1] = inertia[REG_YZ];
  end

  // T row for step 0..2 (row = step), computed at step and held for the W step
  logic signed [39:0] t_nxt [3];
  logic signed [65:0] acc;
  logic [1:0] srow;
  assign srow = step_r[1:0];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      acc = '0;
      for (int k = 0; k < 3; k++)
        acc = acc + 66'($signed(cur_r.r[srow*3+k]) * ib[k][j]);
      t_nxt[j] = 40'((acc + 66'sd32768) >>> 16);
    end
  end

  // W row from the stored T row of step-3; rounded sum fits 48 bits
  logic signed [81:0] wacc;
  assign ti = 2'(step_r - 3'd3);
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wacc = '0;
      for (int k = 0; k < 3; k++)
        wacc = wacc + 82'(t_r[k] * $signed(cur_r.r[j*3+k]));
      wrow[j] = sat32(48'((wacc + 82'sd32768) >>> 16));
    end
  end

  // T rows kept per row for the tensor steps
  logic signed [39:0] tm_r [3][3];
  always_comb for (int k = 0; k < 3; k++) t_r[k] = tm_r[ti][k];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      o_valid_r <= 1'b0;
    end else if (adv) begin
      o_valid_r <= busy_r;
      if (busy_r && step_r != 3'd5) step_r <= step_r + 3'd1;
      else begin
        busy_r <= q_valid;
        step_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (q_ready && q_valid) cur_r <= q_data;
      if (busy_r) begin
        o_r.row_index <= step_r;
        o_r.last <= step_r == 3'd5;
        if (step_r < 3'd3) begin
          tm_r[srow] <= t_nxt;
          o_r.col_a <= cur_r.r[srow*3];
          o_r.col_b <= cur_r.r[srow*3+1];
          o_r.col_c <= cur_r.r[srow*3+2];
          o_r.col_d <= cur_r.pos[srow];
        end else begin
          o_r.col_a <= wrow[0];
          o_r.col_b <= wrow[1];
          o_r.col_c <= wrow[2];
          o_r.col_d <= '0;
        end
      end
    end
  end

  assign out_valid = o_valid_r;
  assign out_data = o_r;
endmodule

/* design/rigid_body_derived_transform.sv */
// Top level: rigid body derived transform, front/queue/back with config regs.
//
//  channel  dir  handshake         payload
//  in_      in   valid/ready       quat_w..z Q2.14, pos_x..z Q16.16
//  out_     out  valid/ready       row_index, col_a..col_d, last
//  cfg_     in   valid/ready       index (3b), data (32b)
//
// The back end emits six row words per body, one per cycle while out_ is not
// stalled, and so sets the sustained body rate. The front registers products,
// then the rounded matrix; the queue lets the front take the next body while
// the back still emits rows. Reset (rst_n low, synchronous) clears all
// control state and the six tensor registers to zero. A stalled out_ word
// holds; the back and then the queue and front back up in turn.
module rigid_body_derived_transform
  import rbdt_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input logic clk,
  input logic rst_n,
  rbdt_in_if.sink in_ch,
  rbdt_out_if.source out_ch,
  rbdt_cfg_if.sink cfg_ch
);
  logic signed [31:0] inertia_r [NUM_REGS];
  logic f_valid, f_ready, b_valid, b_ready;
  xform_t f_data, b_data;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) inertia_r[i] <= '0;
    end else if (cfg_ch.valid && cfg_ch.data.index < 3'(NUM_REGS)) begin
      inertia_r[cfg_ch.data.index] <= cfg_ch.data.data;
    end
  end

  rbdt_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .f_valid, .f_ready, .f_data
  );

  rbdt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  rbdt_back u_back (
    .clk, .rst_n,
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .inertia(inertia_r),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
  );

  // last flags only the sixth row
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.last == (out_ch.data.row_index == 3'd5)))
    else $error("last flag mismatch");
  // rows advance in order when taken
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.data.row_index != 3'd5 |=>
    out_ch.valid && out_ch.data.row_index == $past(out_ch.data.row_index) + 3'd1)
    else $error("row order broken");
  // tensor rows carry no translation
  a_cold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.row_index > 3'd2 |-> out_ch.data.col_d == '0)
    else $error("tensor row col_d nonzero");
endmodule

/* sim/rbdt_checker.sv */
`timescale 1ns / 100ps
// Checker: predicts the six row words per body and compares them with the result channel.
module rbdt_checker
  import rbdt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  rbdt_in_if in_mon,
  rbdt_out_if out_mon,
  rbdt_cfg_if cfg_mon,
  output int fail_count,
  output int rows_pending
);
  logic signed [31:0] tensor_regs [NUM_REGS];
  out_word_t row_queue [$];

  function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int s);
    logic signed [63:0] t;
    t = v + (64'sd1 <<< (s - 1));
    return t >>> s;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  task automatic predict_rows(input in_word_t w);
    logic signed [63:0] qw, qx, qy, qz, one, acc;
    logic signed [63:0] raw [3][3];
    logic signed [63:0] rot [3][3];
    logic signed [63:0] ib [3][3];
    logic signed [63:0] tm [3][3];
    logic signed [63:0] wt [3][3];
    logic signed [63:0] pos [3];
    out_word_t o;
    qw = w.quat_w; qx = w.quat_x; qy = w.quat_y; qz = w.quat_z;
    pos[0] = w.pos_x; pos[1] = w.pos_y; pos[2] = w.pos_z;
    one = 64'sd1 <<< 28;
    raw[0][0] = one - 2*qy*qy - 2*qz*qz;
    raw[0][1] = 2*qx*qy - 2*qw*qz;
    raw[0][2] = 2*qx*qz + 2*qw*qy;
    raw[1][0] = 2*qx*qy + 2*qw*qz;
    raw[1][1] = one - 2*qx*qx - 2*qz*qz;
    raw[1][2] = 2*qy*qz - 2*qw*qx;
    raw[2][0] = 2*qx*qz - 2*qw*qy;
    raw[2][1] = 2*qy*qz + 2*qw*qx;
    raw[2][2] = one - 2*qx*qx - 2*qy*qy;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        rot[i][j] = clamp32(rnd_shr(raw[i][j], 12));
    ib[0][0] = tensor_regs[REG_XX];
    ib[1][1] = tensor_regs[REG_YY];
    ib[2][2] = tensor_regs[REG_ZZ];
    ib[0][1] = tensor_regs[REG_XY]; ib[1][0] = ib[0][1];
    ib[0][2] = tensor_regs[REG_XZ]; ib[2][0] = ib[0][2];
    ib[1][2] = tensor_regs[REG_YZ]; ib[2][1] = ib[1][2];
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += rot[i][k] * ib[k][j];
        tm[i][j] = rnd_shr(acc, 16);
      end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int k = 0; k < 3; k++) acc += tm[i][k] * rot[j][k];
        wt[i][j] = clamp32(rnd_shr(acc, 16));
      end
    for (int i = 0; i < ROWS; i++) begin
      o.row_index = 3'(i);
      o.col_a = (i < 3) ? rot[i][0][31:0] : wt[i-3][0][31:0];
      o.col_b = (i < 3) ? rot[i][1][31:0] : wt[i-3][1][31:0];
      o.col_c = (i < 3) ? rot[i][2][31:0] : wt[i-3][2][31:0];
      o.col_d = (i < 3) ? pos[i][31:0] : 32'sd0;
      o.last = (i == ROWS - 1);
      row_queue.push_back(o);
    end
  endtask

  always @(posedge clk) begin
    out_word_t exp_row;
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) tensor_regs[i] <= 0;
      fail_count <= 0;
      row_queue.delete();
    end else begin
      // results first: a body accepted now cannot produce a row this edge
      if (out_mon.valid && out_mon.ready) begin
        if (row_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected row word %p", out_mon.data);
          fail_count <= fail_count + 1;
        end else begin
          exp_row = row_queue.pop_front();
          if (exp_row !== out_mon.data) begin
            if (fail_count < 10)
              $display("row mismatch: expected %p actual %p", exp_row, out_mon.data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) predict_rows(in_mon.data);
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.data.index < NUM_REGS)
        tensor_regs[cfg_mon.data.index] <= cfg_mon.data.data;
    end
    rows_pending = row_queue.size();
  end
endmodule

/* sim/rigid_body_derived_transform_tb.sv */
`timescale 1ns / 100ps
// Testbench top: stimulus, config phases, back-pressure and verdict.
module rigid_body_derived_transform_tb;
  import rbdt_pkg::*;

  localparam int RAND_BODIES = 400;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst_n;
  int fail_count;
  int rows_pending;
  int cycle_count;
  bit hold_off;      // long receiver stall, driven from its own process

  rbdt_in_if in_ch ();
  rbdt_out_if out_ch ();
  rbdt_cfg_if cfg_ch ();

  rigid_body_derived_transform dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  rbdt_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch), .cfg_mon(cfg_ch),
    .fail_count(fail_count), .rows_pending(rows_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic wait_cycles(input int n);
    repeat (n) @(negedge clk);
  endtask

  // send one word on the body channel, valid held until accepted
  task automatic send_body(input in_word_t w);
    in_ch.valid = 1'b1;
    in_ch.data = w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = '{index: idx, data: val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // block idle: all rows back, then a margin for the pipe
  task automatic drain();
    while (rows_pending != 0) @(negedge clk);
    wait_cycles(20);
  endtask

  task automatic load_tensor(input logic [31:0] xx, yy, zz, xy, xz, yz);
    write_reg(REG_XX, xx);
    write_reg(REG_YY, yy);
    write_reg(REG_ZZ, zz);
    write_reg(REG_XY, xy);
    write_reg(REG_XZ, xz);
    write_reg(REG_YZ, yz);
  endtask

  function automatic logic [15:0] rand_quat();
    int p;
    p = $urandom_range(9);
    if (p < 6) return 16'($urandom_range(16384, 0) - 32'd8192);  // near unit range
    if (p == 6) return $urandom_range(1) ? 16'h7fff : 16'h8000;
    return 16'($urandom());
  endfunction

  function automatic logic [31:0] rand_word();
    int p;
    p = $urandom_range(9);
    if (p < 5) return $urandom_range(32'h40000) - 32'h20000;
    if (p == 5) return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
    return $urandom();
  endfunction

  function automatic in_word_t rand_body();
    in_word_t w;
    w.quat_w = rand_quat();
    w.quat_x = rand_quat();
    w.quat_y = rand_quat();
    w.quat_z = rand_quat();
    w.pos_x = rand_word();
    w.pos_y = rand_word();
    w.pos_z = rand_word();
    return w;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      wait_cycles(gap_len());
      send_body(rand_body());
    end
  endtask

  // receiver: random ready, forced low during the long hold-off
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off) out_ch.ready <= 1'b0;
      else if ($urandom_range(3) == 0) out_ch.ready <= (gap_len() == 0);
      else out_ch.ready <= 1'b1;
    end
  end

  // timeout
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("rigid_body_derived_transform verification failed");
        $finish;
      end
    end
  end

  initial begin
    hold_off = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, tensor still zero after reset: identity, extremes
    send_body('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sd65536, -32'sd65536, 32'sd0});
    send_body('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                32'sh7fffffff, 32'sh80000000, 32'sh7fffffff});
    send_body('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                32'sh80000000, 32'sh7fffffff, 32'sh80000000});
    drain();

    // unit tensor; index beyond five must be ignored
    load_tensor(32'h10000, 32'h10000, 32'h10000, 32'h0, 32'h0, 32'h0);
    write_reg(3'd6, 32'hdeadbeef);
    write_reg(3'd7, 32'h12345678);
    send_body('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_body('{16'sd11585, 16'sd0, 16'sd0, 16'sd11585, 32'sd1, -32'sd1, 32'sd7});
    send_body('{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_body('{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_body('{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 32'sd0, 32'sd0, 32'sd0});
    send_body('{16'sd30000, 16'sd20000, -16'sd20000, 16'sd10000, 32'sd0, 32'sd0, 32'sd0});
    drain();

    // extreme tensor: saturates the world tensor rows
    load_tensor(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                32'h80000000, 32'h7fffffff, 32'h80000000);
    send_body('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 32'sd0, 32'sd0, 32'sd0});
    send_body('{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 32'sd0, 32'sd0, 32'sd0});
    send_body('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192, 32'sd0, 32'sd0, 32'sd0});
    drain();

    // long receiver stall while bodies keep coming: fill the pipe, stall intake
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) send_body(rand_body());
    join
    drain();

    // random phases, each with a fresh tensor
    for (int ph = 0; ph < 4; ph++) begin
      load_tensor(rand_word(), rand_word(), rand_word(),
                  rand_word(), rand_word(), rand_word());
      send_random(RAND_BODIES / 4);
      drain();
    end

    // all-ones tensor words, then back to zero
    load_tensor(32'hffffffff, 32'hffffffff, 32'hffffffff,
                32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_random(5);
    drain();
    load_tensor(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    send_random(5);
    drain();

    if (fail_count == 0)
      $display("rigid_body_derived_transform verification clean");
    else
      $display("rigid_body_derived_transform verification failed");
    $finish;
  end
endmodule
